// ===== rtl/core/jsh_pkg.sv =====
`timescale 1ns / 1ps

package jsh_pkg;

   localparam int MAX_COMPONENTS = 4;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [6:0] SCAN_CAP = 7'd64;
   localparam logic [6:0] COUNTER_TOP = 7'd127;
   localparam logic [3:0] APPROX_MAX = 4'd13;
   localparam logic [3:0] TABLE_MAX = 4'd3;
   localparam logic [15:0] HEADER_FIXED = 16'd6;

   localparam logic [2:0] KIND_COMP = 3'd0;
   localparam logic [2:0] KIND_PARAMS = 3'd1;
   localparam logic [2:0] KIND_DATA = 3'd2;
   localparam logic [2:0] KIND_MARKER = 3'd3;
   localparam logic [2:0] KIND_END = 3'd4;
   localparam logic [2:0] KIND_ERROR = 3'd5;

   localparam logic [2:0] ERR_TRUNCATED = 3'd0;
   localparam logic [2:0] ERR_TOO_MANY_SCANS = 3'd1;
   localparam logic [2:0] ERR_BAD_COUNT = 3'd2;
   localparam logic [2:0] ERR_TABLE = 3'd3;
   localparam logic [2:0] ERR_APPROX = 3'd4;
   localparam logic [2:0] ERR_FF_AT_END = 3'd5;
   localparam logic [2:0] ERR_SHORT_LENGTH = 3'd6;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_LEN_LO,
      PH_COUNT,
      PH_SEL,
      PH_TABLE,
      PH_SS,
      PH_SE,
      PH_APPROX,
      PH_SKIP,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic [7:0] component_id;
      logic [1:0] dc_table;
      logic [1:0] ac_table;
      logic [7:0] spectral_first;
      logic [7:0] spectral_last;
      logic [3:0] approx_high;
      logic [3:0] approx_low;
      logic [2:0] error_code;
      logic [5:0] scan_number;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/core/jsh_parser.sv =====
`timescale 1ns / 1ps

module jsh_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             first_of_segment,
   input  logic             last_of_stream,
   input  logic             clear_count,
   input  logic [6:0]       scan_limit,
   output logic             res_valid,
   output jsh_pkg::rsp_type res
);
   import jsh_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  comp_total_ff, comp_total_in;
   logic [2:0]  comp_index_ff, comp_index_in;
   logic [7:0]  held_sel_ff, held_sel_in;
   logic [7:0]  held_ss_ff, held_ss_in;
   logic [7:0]  held_se_ff, held_se_in;
   logic        pending_ff, pending_in;
   logic [6:0]  counter_ff, counter_in;

   logic [6:0]  counter_now;
   logic [6:0]  limit;
   logic [15:0] need;
   logic [15:0] skip_left;
   logic [2:0]  index_next;

   always_comb begin
      counter_now = clear_count ? 7'd0 : counter_ff;
      limit = (scan_limit > SCAN_CAP) ? SCAN_CAP : scan_limit;
      need = HEADER_FIXED + {7'd0, data_byte, 1'b0};
      skip_left = bytes_left_ff - 16'd1;
      index_next = comp_index_ff + 3'd1;

      phase_in = phase_ff;
      length_high_in = length_high_ff;
      bytes_left_in = bytes_left_ff;
      comp_total_in = comp_total_ff;
      comp_index_in = comp_index_ff;
      held_sel_in = held_sel_ff;
      held_ss_in = held_ss_ff;
      held_se_in = held_se_ff;
      pending_in = pending_ff;
      counter_in = counter_now;

      res_valid = 1'b0;
      res = '0;
      res.scan_number = counter_now[5:0];

      if (first_of_segment) begin
         pending_in = 1'b0;
         comp_index_in = 3'd0;
         if (counter_now >= limit) begin
            res_valid = 1'b1;
            res.kind = KIND_ERROR;
            res.error_code = ERR_TOO_MANY_SCANS;
            phase_in = PH_IDLE;
         end else begin
            length_high_in = data_byte;
            phase_in = PH_LEN_LO;
            if (last_of_stream) begin
               res_valid = 1'b1;
               res.kind = KIND_ERROR;
               res.error_code = ERR_TRUNCATED;
               phase_in = PH_IDLE;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_LEN_LO: begin
               bytes_left_in = {length_high_ff, data_byte};
               phase_in = PH_COUNT;
               if (last_of_stream) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_COUNT: begin
               if (data_byte < 8'd1 || data_byte > 8'(MAX_COMPONENTS)) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_BAD_COUNT;
               end else if (bytes_left_ff < need) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_SHORT_LENGTH;
               end else begin
                  comp_total_in = data_byte[2:0];
                  comp_index_in = 3'd0;
                  bytes_left_in = bytes_left_ff - need;
                  phase_in = PH_SEL;
                  if (last_of_stream) begin
                     res_valid = 1'b1;
                     res.kind = KIND_ERROR;
                     res.error_code = ERR_TRUNCATED;
                  end
               end
            end
            PH_SEL: begin
               held_sel_in = data_byte;
               phase_in = PH_TABLE;
               if (last_of_stream) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_TABLE: begin
               res_valid = 1'b1;
               if (data_byte[7:4] > TABLE_MAX || data_byte[3:0] > TABLE_MAX) begin
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TABLE;
               end else if (last_of_stream) begin
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end else begin
                  res.kind = KIND_COMP;
                  res.component_id = held_sel_ff;
                  res.dc_table = data_byte[5:4];
                  res.ac_table = data_byte[1:0];
                  comp_index_in = index_next;
                  phase_in = (index_next >= comp_total_ff) ? PH_SS : PH_SEL;
               end
            end
            PH_SS: begin
               held_ss_in = data_byte;
               phase_in = PH_SE;
               if (last_of_stream) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_SE: begin
               held_se_in = data_byte;
               phase_in = PH_APPROX;
               if (last_of_stream) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end
            end
            PH_APPROX: begin
               res_valid = 1'b1;
               if (data_byte[7:4] > APPROX_MAX) begin
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_APPROX;
               end else if (last_of_stream && bytes_left_ff != 16'd0) begin
                  res.kind = KIND_ERROR;
                  res.error_code = ERR_TRUNCATED;
               end else begin
                  res.kind = KIND_PARAMS;
                  res.spectral_first = held_ss_ff;
                  res.spectral_last = held_se_ff;
                  res.approx_high = data_byte[7:4];
                  res.approx_low = data_byte[3:0];
                  pending_in = 1'b0;
                  phase_in = (bytes_left_ff != 16'd0) ? PH_SKIP : PH_DATA;
                  if (last_of_stream) begin
                     res.last = 1'b1;
                     if (counter_now < COUNTER_TOP) begin
                        counter_in = counter_now + 7'd1;
                     end
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_SKIP: begin
               bytes_left_in = skip_left;
               if (skip_left == 16'd0) begin
                  phase_in = PH_DATA;
               end
               if (last_of_stream) begin
                  res_valid = 1'b1;
                  if (skip_left != 16'd0) begin
                     res.kind = KIND_ERROR;
                     res.error_code = ERR_TRUNCATED;
                  end else begin
                     res.kind = KIND_END;
                     res.last = 1'b1;
                     if (counter_now < COUNTER_TOP) begin
                        counter_in = counter_now + 7'd1;
                     end
                     phase_in = PH_IDLE;
                     pending_in = 1'b0;
                  end
               end
            end
            PH_DATA: begin
               if (data_byte == MARKER_PREFIX) begin
                  pending_in = 1'b1;
                  if (last_of_stream) begin
                     res_valid = 1'b1;
                     res.kind = KIND_ERROR;
                     res.error_code = ERR_FF_AT_END;
                  end
               end else if (pending_ff && data_byte != 8'd0) begin
                  res_valid = 1'b1;
                  res.kind = KIND_MARKER;
                  res.value = data_byte;
                  res.last = 1'b1;
                  if (counter_now < COUNTER_TOP) begin
                     counter_in = counter_now + 7'd1;
                  end
                  phase_in = PH_IDLE;
                  pending_in = 1'b0;
               end else begin
                  res_valid = 1'b1;
                  res.kind = KIND_DATA;
                  res.value = pending_ff ? MARKER_PREFIX : data_byte;
                  pending_in = 1'b0;
                  if (last_of_stream) begin
                     res.last = 1'b1;
                     if (counter_now < COUNTER_TOP) begin
                        counter_in = counter_now + 7'd1;
                     end
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase

         // Every error ends the scan and drops back to idle.
         if (res_valid && res.kind == KIND_ERROR) begin
            res.last = 1'b1;
            phase_in = PH_IDLE;
            pending_in = 1'b0;
         end
      end

      if (first_of_segment && res_valid) begin
         res.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pending_ff <= 1'b0;
         comp_index_ff <= 3'd0;
         counter_ff <= 7'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pending_ff <= pending_in;
         comp_index_ff <= comp_index_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         length_high_ff <= length_high_in;
         bytes_left_ff <= bytes_left_in;
         comp_total_ff <= comp_total_in;
         held_sel_ff <= held_sel_in;
         held_ss_ff <= held_ss_in;
         held_se_ff <= held_se_in;
      end
   end

endmodule

// ===== rtl/core/jsh_rsp_fifo.sv =====
`timescale 1ns / 1ps

module jsh_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  jsh_pkg::rsp_type wr_data,
   output logic             has_room,
   output logic             rd_valid,
   input  logic             rd_ready,
   output jsh_pkg::rsp_type rd_data
);
   import jsh_pkg::*;

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop = rd_valid && rd_ready;
      wr_ptr_in = wr_en ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, wr_en} - {1'b0, pop};
   end

   assign has_room = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/jpeg_scan_header_and_unstuff_core.sv =====
// Parses a JPEG start-of-scan segment one byte per request, starting at the high length
// byte, then unstuffs the entropy data that follows until a marker or the end of the
// stream. A request is accepted in every cycle while the output queue has room, and its
// result, if any, is written to that two-entry queue on the same edge and, if no older
// result waits, shows on the result port in the next cycle; the parser's state update on
// each accepted request sets this rate, and the queue lets a request be taken while one
// result still waits. When both entries are full, a request waits until a result is read.
// The scan limit is written through the control port and takes effect on the next request.
`timescale 1ns / 1ps

module jpeg_scan_header_and_unstuff_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_segment,
   input  logic       req_last_of_stream,
   input  logic       req_clear_count,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_component_id,
   output logic [1:0] rsp_dc_table,
   output logic [1:0] rsp_ac_table,
   output logic [7:0] rsp_spectral_first,
   output logic [7:0] rsp_spectral_last,
   output logic [3:0] rsp_approx_high,
   output logic [3:0] rsp_approx_low,
   output logic [2:0] rsp_error_code,
   output logic [5:0] rsp_scan_number,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import jsh_pkg::*;

   logic [6:0] scan_limit_ff;
   logic       accept;
   logic       res_valid;
   rsp_type    res;
   rsp_type    out;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= SCAN_CAP;
      end else if (csr_wr_en) begin
         scan_limit_ff <= csr_wr_data;
      end
   end

   jsh_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .first_of_segment (req_first_of_segment),
      .last_of_stream   (req_last_of_stream),
      .clear_count      (req_clear_count),
      .scan_limit       (scan_limit_ff),
      .res_valid        (res_valid),
      .res              (res)
   );

   jsh_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && res_valid),
      .wr_data  (res),
      .has_room (req_ready),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (out)
   );

   assign rsp_kind = out.kind;
   assign rsp_value = out.value;
   assign rsp_component_id = out.component_id;
   assign rsp_dc_table = out.dc_table;
   assign rsp_ac_table = out.ac_table;
   assign rsp_spectral_first = out.spectral_first;
   assign rsp_spectral_last = out.spectral_last;
   assign rsp_approx_high = out.approx_high;
   assign rsp_approx_low = out.approx_low;
   assign rsp_error_code = out.error_code;
   assign rsp_scan_number = out.scan_number;
   assign rsp_last = out.last;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import jsh_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       ends;
      logic       clear;
   } scan_req_type;

   typedef struct {
      scan_req_type stim;
      bit           fixed;
      rsp_type      want;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_first_of_segment = 1'b0;
   logic       req_last_of_stream = 1'b0;
   logic       req_clear_count = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_value;
   logic [7:0] rsp_component_id;
   logic [1:0] rsp_dc_table;
   logic [1:0] rsp_ac_table;
   logic [7:0] rsp_spectral_first;
   logic [7:0] rsp_spectral_last;
   logic [3:0] rsp_approx_high;
   logic [3:0] rsp_approx_low;
   logic [2:0] rsp_error_code;
   logic [5:0] rsp_scan_number;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = 7'd0;

   jpeg_scan_header_and_unstuff_core u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_first_of_segment(req_first_of_segment),
      .req_last_of_stream(req_last_of_stream),
      .req_clear_count(req_clear_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_value(rsp_value),
      .rsp_component_id(rsp_component_id),
      .rsp_dc_table(rsp_dc_table),
      .rsp_ac_table(rsp_ac_table),
      .rsp_spectral_first(rsp_spectral_first),
      .rsp_spectral_last(rsp_spectral_last),
      .rsp_approx_high(rsp_approx_high),
      .rsp_approx_low(rsp_approx_low),
      .rsp_error_code(rsp_error_code),
      .rsp_scan_number(rsp_scan_number),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   phase_type   parse_phase;
   logic [7:0]  length_hi;
   logic [15:0] header_left;
   logic [2:0]  comp_total;
   logic [2:0]  comp_seen;
   logic [7:0]  selector;
   logic [7:0]  spec_first;
   logic [7:0]  spec_last;
   bit          ff_held;
   logic [6:0]  scans_done;
   logic [6:0]  scan_limit;

   rsp_type     due_results[$];
   dir_row_type directed_rows[$];
   int          mismatches = 0;
   int          scan_bytes = 0;
   int          req_max_gap = 4;
   int          rsp_max_stall = 4;
   bit          hold_rsp = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   function automatic void reset_predictor();
      parse_phase = PH_IDLE;
      length_hi = 8'd0;
      header_left = 16'd0;
      comp_total = 3'd0;
      comp_seen = 3'd0;
      selector = 8'd0;
      spec_first = 8'd0;
      spec_last = 8'd0;
      ff_held = 0;
      scans_done = 7'd0;
      scan_limit = SCAN_CAP;
   endfunction

   function automatic rsp_type blank_result(logic [2:0] kind, logic last);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.scan_number = scans_done[5:0];
      r.last = last;
      return r;
   endfunction

   function automatic rsp_type abort_scan(logic [2:0] code);
      rsp_type r;
      r = blank_result(KIND_ERROR, 1'b1);
      r.error_code = code;
      parse_phase = PH_IDLE;
      ff_held = 0;
      return r;
   endfunction

   function automatic void close_scan();
      if (scans_done < COUNTER_TOP) begin
         scans_done = scans_done + 7'd1;
      end
      parse_phase = PH_IDLE;
      ff_held = 0;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte yields a result.
   function automatic bit parse_scan_byte(input scan_req_type q, output rsp_type r);
      logic [7:0] b;
      logic [6:0] lim;
      int         need;
      b = q.data;
      lim = (scan_limit > SCAN_CAP) ? SCAN_CAP : scan_limit;
      r = '0;
      if (q.clear) begin
         scans_done = 7'd0;
      end
      if (q.first) begin
         ff_held = 0;
         comp_seen = 3'd0;
         if (scans_done >= lim) begin
            r = abort_scan(ERR_TOO_MANY_SCANS);
            return 1;
         end
         length_hi = b;
         parse_phase = PH_LEN_LO;
         if (q.ends) begin
            r = abort_scan(ERR_TRUNCATED);
            return 1;
         end
         return 0;
      end
      case (parse_phase)
         PH_LEN_LO: begin
            header_left = {length_hi, b};
            parse_phase = PH_COUNT;
         end
         PH_COUNT: begin
            need = HEADER_FIXED + 2 * b;
            if (b < 1 || b > MAX_COMPONENTS) begin
               r = abort_scan(ERR_BAD_COUNT);
               return 1;
            end
            if (header_left < need) begin
               r = abort_scan(ERR_SHORT_LENGTH);
               return 1;
            end
            comp_total = b[2:0];
            comp_seen = 3'd0;
            header_left = header_left - need[15:0];
            parse_phase = PH_SEL;
         end
         PH_SEL: begin
            selector = b;
            parse_phase = PH_TABLE;
         end
         PH_TABLE: begin
            if (b[7:4] > TABLE_MAX || b[3:0] > TABLE_MAX) begin
               r = abort_scan(ERR_TABLE);
               return 1;
            end
            if (q.ends) begin
               r = abort_scan(ERR_TRUNCATED);
               return 1;
            end
            r = blank_result(KIND_COMP, 1'b0);
            r.component_id = selector;
            r.dc_table = b[5:4];
            r.ac_table = b[1:0];
            comp_seen = comp_seen + 3'd1;
            parse_phase = (comp_seen >= comp_total) ? PH_SS : PH_SEL;
            return 1;
         end
         PH_SS: begin
            spec_first = b;
            parse_phase = PH_SE;
         end
         PH_SE: begin
            spec_last = b;
            parse_phase = PH_APPROX;
         end
         PH_APPROX: begin
            if (b[7:4] > APPROX_MAX) begin
               r = abort_scan(ERR_APPROX);
               return 1;
            end
            if (q.ends && header_left != 16'd0) begin
               r = abort_scan(ERR_TRUNCATED);
               return 1;
            end
            r = blank_result(KIND_PARAMS, q.ends);
            r.spectral_first = spec_first;
            r.spectral_last = spec_last;
            r.approx_high = b[7:4];
            r.approx_low = b[3:0];
            ff_held = 0;
            parse_phase = (header_left != 16'd0) ? PH_SKIP : PH_DATA;
            if (q.ends) begin
               close_scan();
            end
            return 1;
         end
         PH_SKIP: begin
            header_left = header_left - 16'd1;
            if (header_left == 16'd0) begin
               parse_phase = PH_DATA;
            end
            if (q.ends) begin
               if (header_left != 16'd0) begin
                  r = abort_scan(ERR_TRUNCATED);
                  return 1;
               end
               r = blank_result(KIND_END, 1'b1);
               close_scan();
               return 1;
            end
            return 0;
         end
         PH_DATA: begin
            if (b == MARKER_PREFIX) begin
               if (q.ends) begin
                  r = abort_scan(ERR_FF_AT_END);
                  return 1;
               end
               ff_held = 1;
               return 0;
            end
            if (ff_held && b != 8'h00) begin
               ff_held = 0;
               r = blank_result(KIND_MARKER, 1'b1);
               r.value = b;
               close_scan();
               return 1;
            end
            r = blank_result(KIND_DATA, q.ends);
            r.value = ff_held ? MARKER_PREFIX : b;
            ff_held = 0;
            if (q.ends) begin
               close_scan();
            end
            return 1;
         end
         default: begin
            return 0;
         end
      endcase
      if (q.ends) begin
         r = abort_scan(ERR_TRUNCATED);
         return 1;
      end
      return 0;
   endfunction

   function automatic scan_req_type make_req(logic [7:0] d, logic f, logic e, logic c);
      scan_req_type q;
      q.data = d;
      q.first = f;
      q.ends = e;
      q.clear = c;
      return q;
   endfunction

   function automatic void add_plain(scan_req_type q);
      dir_row_type row;
      row.stim = q;
      row.fixed = 0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_error(scan_req_type q, logic [2:0] code, logic [5:0] scan);
      dir_row_type row;
      row.stim = q;
      row.fixed = 1;
      row.want = '0;
      row.want.kind = KIND_ERROR;
      row.want.error_code = code;
      row.want.scan_number = scan;
      row.want.last = 1'b1;
      directed_rows.push_back(row);
   endfunction

   task automatic flag_mismatch(string what, rsp_type got, rsp_type want);
      $display("%0t: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (due_results.size() == 0) begin
         flag_mismatch("result with none pending", got, '0);
      end else begin
         want = due_results.pop_front();
         if (got !== want) flag_mismatch("result", got, want);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         check_result({rsp_kind, rsp_value, rsp_component_id, rsp_dc_table, rsp_ac_table,
                       rsp_spectral_first, rsp_spectral_last, rsp_approx_high,
                       rsp_approx_low, rsp_error_code, rsp_scan_number, rsp_last});
      end
   end

   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = hold_rsp ? 300 : $urandom_range(0, rsp_max_stall);
         hold_rsp = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Each call starts at the falling edge after the previous request was taken.
   task automatic send_req(input scan_req_type q, input bit fixed, input rsp_type want);
      int      gap;
      bit      hit;
      rsp_type res;
      gap = $urandom_range(0, req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= q.data;
      req_first_of_segment <= q.first;
      req_last_of_stream <= q.ends;
      req_clear_count <= q.clear;
      do @(posedge clock); while (req_ready !== 1'b1);
      hit = parse_scan_byte(q, res);
      if (fixed) begin
         due_results.push_back(want);
      end else if (hit) begin
         due_results.push_back(res);
      end
   endtask

   task automatic drain_results(int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_scan_limit(logic [6:0] v);
      drain_results(4);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      scan_limit = v;
   endtask

   task automatic send_random_scan();
      scan_req_type burst[$];
      int        n_comp;
      int        n_head;
      int        need;
      int        len;
      int        n_skip;
      int        n_data;
      int        hdr_len;
      int        cut;
      int        mode;
      logic [7:0] d;
      bit        ff_open;
      n_comp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(1, MAX_COMPONENTS);
      n_head = (n_comp >= 1 && n_comp <= MAX_COMPONENTS) ? n_comp : 1;
      need = HEADER_FIXED + 2 * n_comp;
      n_skip = $urandom_range(0, 3);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         len = $urandom_range(0, need - 1);
      end else if (mode == 1) begin
         len = $urandom_range(0, 16'hFFFF);
      end else begin
         len = need + n_skip;
      end
      burst.push_back(make_req(len[15:8], 1'b1, 1'b0, $urandom_range(0, 3) == 0));
      burst.push_back(make_req(len[7:0], 1'b0, 1'b0, 1'b0));
      burst.push_back(make_req(n_comp[7:0], 1'b0, 1'b0, 1'b0));
      for (int i = 0; i < n_head; i++) begin
         burst.push_back(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
         if ($urandom_range(0, 9) == 0) begin
            d = 8'($urandom_range(0, 255));
         end else begin
            d = {2'b00, 2'($urandom_range(0, 3)), 2'b00, 2'($urandom_range(0, 3))};
         end
         burst.push_back(make_req(d, 1'b0, 1'b0, 1'b0));
      end
      burst.push_back(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
      burst.push_back(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
      if ($urandom_range(0, 9) == 0) begin
         d = 8'($urandom_range(0, 255));
      end else begin
         d = {4'($urandom_range(0, 13)), 4'($urandom_range(0, 15))};
      end
      burst.push_back(make_req(d, 1'b0, 1'b0, 1'b0));
      repeat (n_skip) burst.push_back(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0));
      hdr_len = burst.size();
      n_data = $urandom_range(0, 12);
      ff_open = 0;
      for (int i = 0; i < n_data; i++) begin
         if (ff_open) begin
            d = ($urandom_range(0, 2) == 0) ? MARKER_PREFIX : 8'h00;
         end else begin
            d = ($urandom_range(0, 3) == 0) ? MARKER_PREFIX : 8'($urandom_range(0, 255));
         end
         ff_open = (d == MARKER_PREFIX);
         burst.push_back(make_req(d, 1'b0, 1'b0, 1'b0));
      end
      case ($urandom_range(0, 3))
         0, 1: begin
            if (!ff_open) begin
               burst.push_back(make_req(MARKER_PREFIX, 1'b0, 1'b0, 1'b0));
            end
            burst.push_back(make_req(8'($urandom_range(1, 254)), 1'b0, 1'b0, 1'b0));
         end
         2: begin
            d = ($urandom_range(0, 3) == 0) ? MARKER_PREFIX : 8'($urandom_range(0, 255));
            burst.push_back(make_req(d, 1'b0, 1'b1, 1'b0));
         end
         default: begin
         end
      endcase
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(0, hdr_len - 1);
         burst[cut].ends = 1'b1;
         while (burst.size() > cut + 1) burst.pop_back();
      end
      foreach (burst[i]) begin
         send_req(burst[i], 0, '0);
         scan_bytes++;
      end
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_req(make_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                              $urandom_range(0, 7) == 0), 0, '0);
         end
      end
   endtask

   initial begin
      logic [6:0] limits[8];
      int         phase_end;
      limits = '{7'd1, 7'd127, 7'd0, 7'd3, 7'd64, 7'd2, 7'd100, 7'd5};
      reset_predictor();

      add_plain(make_req(8'h00, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h00, 1'b1, 1'b0, 1'b0));
      add_plain(make_req(8'h09, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h01, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hFF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h33, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h00, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hFF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hDF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hAB, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hFF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h00, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hFF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hFF, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'hD9, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h00, 1'b1, 1'b0, 1'b0));
      add_plain(make_req(8'h03, 1'b0, 1'b0, 1'b0));
      add_error(make_req(8'h01, 1'b0, 1'b0, 1'b0), ERR_SHORT_LENGTH, 6'd1);
      add_plain(make_req(8'h00, 1'b1, 1'b0, 1'b0));
      add_plain(make_req(8'h10, 1'b0, 1'b0, 1'b0));
      add_error(make_req(8'h05, 1'b0, 1'b0, 1'b0), ERR_BAD_COUNT, 6'd1);
      add_error(make_req(8'h00, 1'b1, 1'b1, 1'b0), ERR_TRUNCATED, 6'd1);
      add_plain(make_req(8'h00, 1'b1, 1'b0, 1'b1));
      add_plain(make_req(8'h08, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h01, 1'b0, 1'b0, 1'b0));
      add_plain(make_req(8'h00, 1'b0, 1'b0, 1'b0));
      add_error(make_req(8'h40, 1'b0, 1'b0, 1'b0), ERR_TABLE, 6'd0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
      end

      for (int p = 0; p < 8; p++) begin
         write_scan_limit(limits[p]);
         req_max_gap = (p == 2) ? 0 : 4;
         rsp_max_stall = (p == 2) ? 0 : 4;
         if (p == 4) begin
            hold_rsp = 1;
         end
         phase_end = (p + 1) * 203;
         while (scan_bytes < phase_end) send_random_scan();
      end

      drain_results(10);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/jsh_pkg.sv
rtl/core/jsh_parser.sv
rtl/core/jsh_rsp_fifo.sv
rtl/core/jpeg_scan_header_and_unstuff_core.sv
bench/testbench.sv
